// ===== rtl/aet_pkg.sv =====
// ----------------------------------------------------------------------------
// aet_pkg
// Shared types, token codes and helpers for the expression tokenizer.
// ----------------------------------------------------------------------------
package aet_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FIFO_PTR_BITS-1:0] fifo_ptr_t;
  typedef logic [FIFO_CNT_BITS-1:0] fifo_cnt_t;

  localparam count_t COUNT_MAX = '1;
  localparam count_t COUNT_ONE = count_t'(1);

  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_PLUS    = 3'd1;
  localparam logic [2:0] KIND_MINUS   = 3'd2;
  localparam logic [2:0] KIND_STAR    = 3'd3;
  localparam logic [2:0] KIND_SLASH   = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_INVALID = 3'd6;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
  } token_pos_t;

  typedef struct packed {
    logic       has_num;
    token_pos_t num;
    logic       has_op;
    logic [2:0] op_kind;
    token_pos_t op;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic logic [15:0] clip16(count_t v);
    logic [15:0] r;
    if (v > count_t'(17'h0FFFF)) begin
      r = 16'hFFFF;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic count_t sat_inc(count_t v);
    count_t r;
    if (v == COUNT_MAX) begin
      r = v;
    end else begin
      r = v + COUNT_ONE;
    end
    return r;
  endfunction

endpackage

// ===== rtl/aet_front.sv =====
// ----------------------------------------------------------------------------
// aet_front
// Accepts source bytes, keeps position counters and builds token entries.
// ----------------------------------------------------------------------------
module aet_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           ch,
  input  aet_pkg::fifo_status_t q_status,
  output logic                 push,
  output aet_pkg::entry_t      push_entry
);
  import aet_pkg::*;

  count_t byte_position;
  count_t line_count;
  count_t column_count;
  logic   in_number;
  count_t number_start;
  count_t number_line;
  count_t number_column;
  logic   halted;

  logic       accept;
  logic       active;
  logic       digit;
  logic       space;
  logic [2:0] op_kind;
  count_t     line_next;
  count_t     column_next;
  count_t     position_next;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign active   = accept && !halted;

  always_comb begin
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    case (ch)
      CH_PLUS:  op_kind = KIND_PLUS;
      CH_MINUS: op_kind = KIND_MINUS;
      CH_STAR:  op_kind = KIND_STAR;
      CH_SLASH: op_kind = KIND_SLASH;
      CH_NUL:   op_kind = KIND_END;
      default:  op_kind = KIND_INVALID;
    endcase
  end

  // counters after this byte
  always_comb begin
    if (ch == CH_NEWLINE) begin
      line_next   = sat_inc(line_count);
      column_next = COUNT_ONE;
    end else begin
      line_next   = line_count;
      column_next = sat_inc(column_count);
    end
    position_next = sat_inc(byte_position);
  end

  always_comb begin
    push_entry.has_num        = in_number && !digit;
    push_entry.num.start      = clip16(number_start);
    push_entry.num.length     = clip16(byte_position - number_start);
    push_entry.num.line       = clip16(number_line);
    push_entry.num.column     = clip16(number_column);
    push_entry.has_op         = !digit && !space;
    push_entry.op_kind        = op_kind;
    push_entry.op.start       = clip16(byte_position);
    push_entry.op.length      = (op_kind == KIND_END) ? 16'd0 : 16'd1;
    push_entry.op.line        = clip16(line_count);
    push_entry.op.column      = clip16(column_count);
  end

  assign push = active && (push_entry.has_num || push_entry.has_op);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      line_count    <= COUNT_ONE;
      column_count  <= COUNT_ONE;
      in_number     <= 1'b0;
      number_start  <= '0;
      number_line   <= COUNT_ONE;
      number_column <= COUNT_ONE;
      halted        <= 1'b0;
    end else if (active) begin
      if (digit) begin
        if (!in_number) begin
          in_number     <= 1'b1;
          number_start  <= byte_position;
          number_line   <= line_count;
          number_column <= column_count;
        end
      end else begin
        in_number <= 1'b0;
      end
      if (!digit && !space && (op_kind == KIND_END || op_kind == KIND_INVALID)) begin
        halted <= 1'b1;
      end else begin
        byte_position <= position_next;
        line_count    <= line_next;
        column_count  <= column_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted && $stable(byte_position))
    else $error("halted state left or position moved");
  a_no_push_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !push)
    else $error("entry built after halt");
`endif

endmodule

// ===== rtl/aet_fifo.sv =====
// ----------------------------------------------------------------------------
// aet_fifo
// Short entry queue between the byte front end and the token back end.
// ----------------------------------------------------------------------------
module aet_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  aet_pkg::entry_t       push_entry,
  input  logic                  pop,
  output aet_pkg::entry_t       head,
  output aet_pkg::fifo_status_t status
);
  import aet_pkg::*;

  entry_t    mem [FIFO_DEPTH];
  fifo_ptr_t wr_ptr;
  fifo_ptr_t rd_ptr;
  fifo_cnt_t count;

  function automatic fifo_ptr_t ptr_inc(fifo_ptr_t p);
    fifo_ptr_t r;
    if (p == fifo_ptr_t'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + fifo_ptr_t'(1);
    end
    return r;
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == fifo_cnt_t'(FIFO_DEPTH));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + fifo_cnt_t'(1);
      end else if (pop && !push) begin
        count <= count - fifo_cnt_t'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/aet_back.sv =====
// ----------------------------------------------------------------------------
// aet_back
// Drains queued entries and presents one token per output transaction.
// ----------------------------------------------------------------------------
module aet_back (
  input  logic                  clk,
  input  logic                  rst,
  input  aet_pkg::fifo_status_t q_status,
  input  aet_pkg::entry_t       head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            token_kind,
  output logic [15:0]           token_start,
  output logic [15:0]           token_length,
  output logic [15:0]           token_line,
  output logic [15:0]           token_column,
  output logic                  last_of_run
);
  import aet_pkg::*;

  logic num_done;
  logic load;
  logic send_num;

  assign load     = (!out_valid || !out_stall) && !q_status.empty;
  assign send_num = head.has_num && !num_done;
  assign pop      = load && !(send_num && head.has_op);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      num_done  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        num_done  <= send_num && head.has_op;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_num) begin
        token_kind   <= KIND_NUMBER;
        token_start  <= head.num.start;
        token_length <= head.num.length;
        token_line   <= head.num.line;
        token_column <= head.num.column;
        last_of_run  <= !head.has_op;
      end else begin
        token_kind   <= head.op_kind;
        token_start  <= head.op.start;
        token_length <= head.op.length;
        token_line   <= head.op.line;
        token_column <= head.op.column;
        last_of_run  <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind == KIND_END) |-> last_of_run)
    else $error("end token not marked last");
`endif

endmodule

// ===== rtl/arith_expression_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// arith_expression_tokenizer_unit
// Byte-stream tokenizer for integer arithmetic expressions.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle unless stalled. The front end classifies
// each byte and updates position, line and column, building one queue entry
// with up to two tokens; the back end sends one token per output transaction,
// so a byte that closes a number and is itself an operator yields two tokens.
// A four-entry queue between the two lets either side stall alone. Input stall
// rises only when that queue is full. After an end or invalid-character token
// all further bytes are accepted and dropped until reset.
module arith_expression_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic        last_of_run
);
  import aet_pkg::*;

  logic         push;
  logic         pop;
  entry_t       push_entry;
  entry_t       head;
  fifo_status_t q_status;

  aet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  aet_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  aet_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_line   (token_line),
    .token_column (token_column),
    .last_of_run  (last_of_run)
  );

endmodule
